>>> design/prqr_pkg.sv
// ----------------------------------------------------------------------------
// prqr_pkg
// Shared types and constants for the paced report queue with retry.
// ----------------------------------------------------------------------------
package prqr_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int PAYLOAD_BITS = 64;
   localparam int PTR_W        = $clog2(QUEUE_DEPTH);

   localparam int CMDQ_DEPTH   = 2;
   localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

   localparam int RETRY_GAP_MS = 15;
   localparam int MIN_START_MS = 2;
   localparam int MAX_RAW_LEN  = 8;

   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_TICK    = 2'd1;
   localparam logic [1:0] ACT_CLEAR   = 2'd2;
   localparam logic [1:0] ACT_UNUSED  = 2'd3;

   localparam logic [2:0] RPT_NONE     = 3'd0;
   localparam logic [2:0] RPT_KEYBOARD = 3'd1;
   localparam logic [2:0] RPT_NKRO     = 3'd2;
   localparam logic [2:0] RPT_CONSUMER = 3'd3;
   localparam logic [2:0] RPT_SYSTEM   = 3'd4;
   localparam logic [2:0] RPT_RAW_HID  = 3'd5;

   localparam logic CSR_SEND_INTERVAL = 1'b0;
   localparam logic CSR_RETRY_COUNT   = 1'b1;

   typedef enum logic [1:0] {
      OP_ENQUEUE,
      OP_TICK,
      OP_CLEAR,
      OP_IDLE
   } op_type;

   typedef struct packed {
      logic [3:0]  length;
      logic [15:0] usage;
      logic [2:0]  rtype;
   } meta_type;

   localparam int META_W = $bits(meta_type);
   localparam int SLOT_W = META_W + PAYLOAD_BITS;

   typedef struct packed {
      meta_type                meta;
      logic [PAYLOAD_BITS-1:0] payload;
   } slot_type;

   typedef struct packed {
      op_type   op;
      slot_type slot;
   } cmd_type;

   typedef enum logic {
      ST_FETCH,
      ST_EXEC
   } back_state_type;

endpackage

>>> design/paced_report_queue_with_retry.sv
// ----------------------------------------------------------------------------
// paced_report_queue_with_retry
// Report ring queue with a millisecond paced sender and timed resends.
// ----------------------------------------------------------------------------
//  channel   ports                        direction   transfer
//  req       req_valid / req_stall        in          valid && !stall
//  rsp       rsp_valid / rsp_stall        out         valid && !stall
//  csr       csr_we / csr_index / wdata   in          csr_we
//
//  per item, the fetch state pops the command and starts the ring slot read,
//  and the execution state updates state and loads the result register
//  a two-entry command queue lets up to two items in while the back is busy
//  a stalled result holds the execution stage; reset is synchronous, high
// ----------------------------------------------------------------------------
module paced_report_queue_with_retry
   import prqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_report_type,
   input  logic [63:0] req_report_payload,
   input  logic [15:0] req_report_usage,
   input  logic [3:0]  req_report_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_enqueue_accepted,
   output logic        rsp_send_valid,
   output logic [2:0]  rsp_send_type,
   output logic [63:0] rsp_send_payload,
   output logic [15:0] rsp_send_usage,
   output logic [3:0]  rsp_send_length,
   output logic        rsp_queue_empty,
   output logic [7:0]  rsp_retries_left
);

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_not_empty;
   cmd_type q_push_data;
   cmd_type q_pop_data;

   prqr_front u_front (
      .req_valid          (req_valid),
      .req_action         (req_action),
      .req_report_type    (req_report_type),
      .req_report_payload (req_report_payload),
      .req_report_usage   (req_report_usage),
      .req_report_length  (req_report_length),
      .q_full             (q_full),
      .req_stall          (req_stall),
      .q_push             (q_push),
      .q_data             (q_push_data)
   );

   prqr_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_pop_data)
   );

   prqr_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .q_not_empty          (q_not_empty),
      .q_data               (q_pop_data),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_enqueue_accepted (rsp_enqueue_accepted),
      .rsp_send_valid       (rsp_send_valid),
      .rsp_send_type        (rsp_send_type),
      .rsp_send_payload     (rsp_send_payload),
      .rsp_send_usage       (rsp_send_usage),
      .rsp_send_length      (rsp_send_length),
      .rsp_queue_empty      (rsp_queue_empty),
      .rsp_retries_left     (rsp_retries_left)
   );

endmodule

>>> design/prqr_ram.sv
// ----------------------------------------------------------------------------
// prqr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module prqr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/prqr_front.sv
// ----------------------------------------------------------------------------
// prqr_front
// Decodes the action of an incoming transfer and normalizes its report fields.
// ----------------------------------------------------------------------------
module prqr_front
   import prqr_pkg::*;
(
   input  logic        req_valid,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_report_type,
   input  logic [63:0] req_report_payload,
   input  logic [15:0] req_report_usage,
   input  logic [3:0]  req_report_length,
   input  logic        q_full,
   output logic        req_stall,
   output logic        q_push,
   output cmd_type     q_data
);

   always_comb begin
      q_data.slot.payload     = req_report_payload[PAYLOAD_BITS-1:0];
      q_data.slot.meta.rtype  = req_report_type;
      q_data.slot.meta.usage  = req_report_usage;
      // raw length saturates
      if (req_report_length > 4'(MAX_RAW_LEN)) begin
         q_data.slot.meta.length = 4'(MAX_RAW_LEN);
      end else begin
         q_data.slot.meta.length = req_report_length;
      end
      unique case (req_action)
         ACT_ENQUEUE: q_data.op = OP_ENQUEUE;
         ACT_TICK:    q_data.op = OP_TICK;
         ACT_CLEAR:   q_data.op = OP_CLEAR;
         ACT_UNUSED:  q_data.op = OP_IDLE;
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

>>> design/prqr_cmdq.sv
// ----------------------------------------------------------------------------
// prqr_cmdq
// Short command queue between the front decode and the back execution.
// ----------------------------------------------------------------------------
module prqr_cmdq
   import prqr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_data
);

   cmd_type               entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/prqr_back.sv
// ----------------------------------------------------------------------------
// prqr_back
// Report ring, millisecond count, paced sender with retry, result register.
// ----------------------------------------------------------------------------
module prqr_back
   import prqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        q_not_empty,
   input  cmd_type     q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_enqueue_accepted,
   output logic        rsp_send_valid,
   output logic [2:0]  rsp_send_type,
   output logic [63:0] rsp_send_payload,
   output logic [15:0] rsp_send_usage,
   output logic [3:0]  rsp_send_length,
   output logic        rsp_queue_empty,
   output logic [7:0]  rsp_retries_left
);

   back_state_type          state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [7:0]              send_interval_ff, send_interval_in;
   logic [7:0]              retry_count_ff, retry_count_in;
   logic [PTR_W-1:0]        wp_ff, wp_in;
   logic [PTR_W-1:0]        rp_ff, rp_in;
   slot_type                held_ff, held_in;
   logic [7:0]              retry_ff, retry_in;
   logic [31:0]             now_ff, now_in;
   logic [31:0]             last_send_ff, last_send_in;
   logic [31:0]             last_try_ff, last_try_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    acc_ff, acc_in;
   logic                    svalid_ff, svalid_in;
   logic [2:0]              stype_ff, stype_in;
   logic [63:0]             spay_ff, spay_in;
   logic [15:0]             susage_ff, susage_in;
   logic [3:0]              slen_ff, slen_in;
   logic                    empty_ff, empty_in;
   logic [7:0]              retries_ff, retries_in;

   logic                    ram_we;
   logic [SLOT_W-1:0]       ram_rd_raw;
   slot_type                ram_slot;

   logic                    out_free;
   logic                    is_tick;
   logic                    nonempty;
   logic [31:0]             now_next;
   logic [PTR_W-1:0]        wp_next;
   logic [PTR_W-1:0]        rp_next;
   logic                    send_gate;
   logic                    do_dequeue;
   logic                    do_retry;
   logic                    first_send;
   logic                    pending;
   slot_type                sel_slot;

   prqr_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (cmd_ff.slot),
      .rd_addr (rp_ff),
      .rd_data (ram_rd_raw)
   );

   assign ram_slot   = ram_rd_raw;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_tick    = (cmd_ff.op == OP_TICK);
   assign nonempty   = (wp_ff != rp_ff);
   assign now_next   = now_ff + 32'd1;
   assign wp_next    = (wp_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rp_next    = (rp_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign send_gate  = is_tick && (nonempty || (retry_ff != '0))
                       && ((now_next - last_send_ff) > 32'(send_interval_ff));
   assign do_dequeue = send_gate && (retry_ff == '0);
   assign do_retry   = send_gate && (retry_ff != '0)
                       && ((now_next - last_try_ff) > 32'(RETRY_GAP_MS));
   assign sel_slot   = do_dequeue ? ram_slot : held_ff;
   assign first_send = do_dequeue && (sel_slot.meta.rtype != RPT_NONE)
                       && (now_next > 32'(MIN_START_MS));
   assign pending    = first_send || do_retry;

   // configuration writes
   always_comb begin
      send_interval_in = send_interval_ff;
      retry_count_in   = retry_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SEND_INTERVAL: send_interval_in = csr_wdata;
            CSR_RETRY_COUNT:   retry_count_in   = csr_wdata;
         endcase
      end
   end

   // sent report fields
   always_comb begin
      svalid_in = 1'b0;
      stype_in  = '0;
      spay_in   = '0;
      susage_in = '0;
      slen_in   = '0;
      if (pending) begin
         case (sel_slot.meta.rtype) inside
            RPT_KEYBOARD, RPT_NKRO: begin
               svalid_in = 1'b1;
               stype_in  = sel_slot.meta.rtype;
               spay_in   = 64'(sel_slot.payload);
            end
            RPT_CONSUMER, RPT_SYSTEM: begin
               svalid_in = 1'b1;
               stype_in  = sel_slot.meta.rtype;
               susage_in = sel_slot.meta.usage;
            end
            RPT_RAW_HID: begin
               svalid_in = 1'b1;
               stype_in  = sel_slot.meta.rtype;
               spay_in   = 64'(sel_slot.payload);
               slen_in   = sel_slot.meta.length;
            end
            default: begin
               svalid_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      held_in      = held_ff;
      retry_in     = retry_ff;
      now_in       = now_ff;
      last_send_in = last_send_ff;
      last_try_in  = last_try_ff;
      acc_in       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_FETCH: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               unique case (cmd_ff.op)
                  OP_ENQUEUE: begin
                     if (wp_next != rp_ff) begin
                        ram_we = 1'b1;
                        wp_in  = wp_next;
                        acc_in = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     now_in = now_next;
                     if (do_dequeue) begin
                        held_in = ram_slot;
                        rp_in   = rp_next;
                     end
                     if (first_send) begin
                        retry_in    = retry_count_ff;
                        last_try_in = now_next;
                     end
                     if (do_retry) begin
                        retry_in    = retry_ff - 8'd1;
                        last_try_in = now_next;
                     end
                     if (pending) begin
                        last_send_in = now_next;
                     end
                  end
                  OP_CLEAR: begin
                     wp_in       = '0;
                     rp_in       = '0;
                     retry_in    = '0;
                     last_try_in = '0;
                     held_in     = '0;
                  end
                  OP_IDLE: begin
                     acc_in = 1'b0;
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = ST_FETCH;
            end
         end
      endcase
      empty_in   = (wp_in == rp_in);
      retries_in = retry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FETCH;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_interval_ff <= 8'd8;
         retry_count_ff   <= 8'd3;
         wp_ff            <= '0;
         rp_ff            <= '0;
         held_ff          <= '0;
         retry_ff         <= '0;
         now_ff           <= '0;
         last_send_ff     <= '0;
         last_try_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         send_interval_ff <= send_interval_in;
         retry_count_ff   <= retry_count_in;
         wp_ff            <= wp_in;
         rp_ff            <= rp_in;
         held_ff          <= held_in;
         retry_ff         <= retry_in;
         now_ff           <= now_in;
         last_send_ff     <= last_send_in;
         last_try_ff      <= last_try_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // command and result payload
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (state_ff == ST_EXEC && out_free) begin
         acc_ff     <= acc_in;
         svalid_ff  <= svalid_in;
         stype_ff   <= stype_in;
         spay_ff    <= spay_in;
         susage_ff  <= susage_in;
         slen_ff    <= slen_in;
         empty_ff   <= empty_in;
         retries_ff <= retries_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_enqueue_accepted = acc_ff;
   assign rsp_send_valid       = svalid_ff;
   assign rsp_send_type        = stype_ff;
   assign rsp_send_payload     = spay_ff;
   assign rsp_send_usage       = susage_ff;
   assign rsp_send_length      = slen_ff;
   assign rsp_queue_empty      = empty_ff;
   assign rsp_retries_left     = retries_ff;

endmodule
